### design/mvf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the majority vote fusion unit.
// No dependencies; imported by every other file of the block except mvf_ram.
package mvf_pkg;

  localparam int MVF_MAX_CLASSES = 16;
  localparam int MVF_MAX_MODELS  = 16;

  localparam int SCORE_W = 16;
  localparam int VOTE_W  = 5;
  localparam int IDX_W   = 4;
  localparam int CFG_W   = 5;
  localparam int CFG_AW  = 2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_NUM_CLASSES = 2'd0;
  localparam logic [CFG_AW-1:0] REG_NUM_MODELS  = 2'd1;

  localparam logic [CFG_W-1:0] NUM_CLASSES_RST = 5'd2;
  localparam logic [CFG_W-1:0] NUM_MODELS_RST  = 5'd1;

  localparam logic [VOTE_W-1:0] VOTE_MAX = '1;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               available;
  } mvf_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  class_index;
    logic [VOTE_W-1:0] vote_count;
    logic [IDX_W-1:0]  winner;
    logic              tie;
    logic              no_data;
    logic              last;
  } mvf_out_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic vote_rd;
    logic vote_wr;
    logic scan_rd;
    logic emit_rd;
    logic emit_ld;
    logic idx_clr;
    logic idx_inc;
    logic clr_round;
  } mvf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cls_last;
    logic mdl_last;
    logic rnd_end;
    logic idx_last;
    logic out_free;
  } mvf_sts_t;

endpackage

### design/majority_vote_fusion_unit.sv
`timescale 1ns / 1ps
// Top level of the majority vote fusion unit: controller plus datapath.
// Uses mvf_pkg, mvf_ctrl and mvf_dp.
//
//   channel  direction  ports                       payload
//   in       input      in_valid/in_stall/in_data    score, available
//   out      output     out_valid/out_stall/out_data class_index .. last
//   cfg      input      cfg_we/cfg_addr/cfg_wdata    num_classes, num_models
//
// A score is taken while idle; after the final score of an available model,
// the vote counter is read through the counter RAM's registered read, then written back.
// At the end of a round the scan reads every class counter, then each result
// takes a RAM read, then a load of the output register once that register is free.
// Reset is synchronous; counters are cleared at once by per-class valid bits.
// out_stall holds the output register; in_stall is high outside score intake.
module majority_vote_fusion_unit #(
  parameter int MAX_CLASSES = mvf_pkg::MVF_MAX_CLASSES,
  parameter int MAX_MODELS  = mvf_pkg::MVF_MAX_MODELS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [mvf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [mvf_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  mvf_pkg::mvf_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output mvf_pkg::mvf_out_t          out_data
);
  import mvf_pkg::*;

  mvf_cmd_t cmd;
  mvf_sts_t sts;

  mvf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_available (in_data.available),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  mvf_dp #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_MODELS  (MAX_MODELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### design/mvf_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mvf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/mvf_ctrl.sv
`timescale 1ns / 1ps
// Controller of the majority vote fusion unit: sequences score intake,
// counter update, end-of-round scan and result emission. Uses mvf_pkg.
module mvf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_available,
  output logic              in_stall,
  input  mvf_pkg::mvf_sts_t sts,
  output mvf_pkg::mvf_cmd_t cmd
);
  import mvf_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_VRD   = 3'd1;
  localparam logic [2:0] ST_VWR   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_SDONE = 3'd4;
  localparam logic [2:0] ST_ERD   = 3'd5;
  localparam logic [2:0] ST_ELD   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.cls_last) begin
            if (in_available) begin
              state_nxt = ST_VRD;
            end else if (sts.mdl_last) begin
              cmd.idx_clr = 1'b1;
              state_nxt   = ST_SCAN;
            end
          end
        end
      end
      ST_VRD: begin
        cmd.vote_rd = 1'b1;
        state_nxt   = ST_VWR;
      end
      ST_VWR: begin
        cmd.vote_wr = 1'b1;
        if (sts.rnd_end) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = ST_SCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.idx_last) begin
          state_nxt = ST_SDONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_SDONE: begin
        // last scan read lands this cycle
        cmd.idx_clr = 1'b1;
        state_nxt   = ST_ERD;
      end
      ST_ERD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_ELD;
      end
      ST_ELD: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          if (sts.idx_last) begin
            cmd.clr_round = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_ERD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_vote_pair: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_VRD |=> cmd.vote_wr)
    else $error("counter read not followed by its write");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_ld |-> sts.out_free)
    else $error("result loaded into a busy output register");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> !cmd.vote_wr && !cmd.emit_ld && !cmd.scan_rd)
    else $error("score taken while round work is in progress");

endmodule

### design/mvf_dp.sv
`timescale 1ns / 1ps
// Datapath of the majority vote fusion unit: config registers, per-model best
// score tracking, vote counter RAM, winner scan and output register.
// Uses mvf_pkg and mvf_ram.
module mvf_dp #(
  parameter int MAX_CLASSES = mvf_pkg::MVF_MAX_CLASSES,
  parameter int MAX_MODELS  = mvf_pkg::MVF_MAX_MODELS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mvf_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [mvf_pkg::CFG_W-1:0]     cfg_wdata,
  input  mvf_pkg::mvf_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mvf_pkg::mvf_out_t             out_data,
  input  mvf_pkg::mvf_cmd_t             cmd,
  output mvf_pkg::mvf_sts_t             sts
);
  import mvf_pkg::*;

  localparam int CW = $clog2(MAX_CLASSES);
  localparam int MW = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;

  logic [CFG_W-1:0]   ncls_r;
  logic [CFG_W-1:0]   nmdl_r;
  logic [CW-1:0]      nc_last;
  logic [MW-1:0]      nm_last;

  logic [SCORE_W-1:0] best_score_r;
  logic [CW-1:0]      best_class_r;
  logic [CW-1:0]      class_pos_r;
  logic [MW-1:0]      model_pos_r;
  logic               any_data_r;
  logic               rnd_end_r;
  logic [CW-1:0]      idx_r;
  logic [MAX_CLASSES-1:0] vld_r;
  logic               rd_vld_r;

  logic               scan_v_r;
  logic [CW-1:0]      pidx_r;
  logic [VOTE_W-1:0]  top_r;
  logic [CW-1:0]      win_r;
  logic               tie_r;

  logic               out_valid_r;
  mvf_out_t           out_r;

  logic               cfg_hit;
  logic               clr;
  logic               ram_re;
  logic [CW-1:0]      ram_raddr;
  logic [VOTE_W-1:0]  ram_rdata;
  logic [VOTE_W-1:0]  cnt;
  logic [VOTE_W-1:0]  cnt_inc;

  // effective counts: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (ncls_r == '0) begin
      nc_last = '0;
    end else if (7'(ncls_r) > 7'(MAX_CLASSES)) begin
      nc_last = CW'(MAX_CLASSES - 1);
    end else begin
      nc_last = CW'(ncls_r - 5'd1);
    end
    if (nmdl_r == '0) begin
      nm_last = '0;
    end else if (7'(nmdl_r) > 7'(MAX_MODELS)) begin
      nm_last = MW'(MAX_MODELS - 1);
    end else begin
      nm_last = MW'(nmdl_r - 5'd1);
    end
  end

  assign cfg_hit = cfg_we && (cfg_addr == REG_NUM_CLASSES || cfg_addr == REG_NUM_MODELS);
  assign clr     = cfg_hit || cmd.clr_round;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncls_r <= NUM_CLASSES_RST;
      nmdl_r <= NUM_MODELS_RST;
    end else if (cfg_we) begin
      if (cfg_addr == REG_NUM_CLASSES) begin
        ncls_r <= cfg_wdata;
      end else if (cfg_addr == REG_NUM_MODELS) begin
        nmdl_r <= cfg_wdata;
      end
    end
  end

  // vote counters; an entry without its valid bit reads as zero
  assign ram_re    = cmd.vote_rd || cmd.scan_rd || cmd.emit_rd;
  assign ram_raddr = cmd.vote_rd ? best_class_r : idx_r;
  assign cnt       = rd_vld_r ? ram_rdata : '0;
  assign cnt_inc   = (cnt < VOTE_MAX) ? cnt + 5'd1 : cnt;

  mvf_ram #(
    .WIDTH (VOTE_W),
    .DEPTH (MAX_CLASSES)
  ) u_votes (
    .clk   (clk),
    .we    (cmd.vote_wr),
    .waddr (best_class_r),
    .wdata (cnt_inc),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (cmd.vote_wr) begin
      vld_r[best_class_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_vld_r <= vld_r[ram_raddr];
    end
  end

  // score intake and round position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_score_r <= '0;
      best_class_r <= '0;
      class_pos_r  <= '0;
      model_pos_r  <= '0;
      any_data_r   <= 1'b0;
      rnd_end_r    <= 1'b0;
    end else if (clr) begin
      best_score_r <= '0;
      best_class_r <= '0;
      class_pos_r  <= '0;
      model_pos_r  <= '0;
      any_data_r   <= 1'b0;
      rnd_end_r    <= 1'b0;
    end else if (cmd.take) begin
      // first class, or a strictly higher score, takes the lead
      if (class_pos_r == '0 || in_data.score > best_score_r) begin
        best_score_r <= in_data.score;
        best_class_r <= class_pos_r;
      end
      if (class_pos_r == nc_last) begin
        class_pos_r <= '0;
        rnd_end_r   <= (model_pos_r == nm_last);
        if (in_data.available) begin
          any_data_r <= 1'b1;
        end
        if (model_pos_r == nm_last) begin
          model_pos_r <= '0;
        end else begin
          model_pos_r <= model_pos_r + 1'b1;
        end
      end else begin
        class_pos_r <= class_pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // winner scan: data of the read issued last cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_v_r <= 1'b0;
    end else begin
      scan_v_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= idx_r;
    if (scan_v_r) begin
      if (pidx_r == '0) begin
        top_r <= cnt;
        win_r <= '0;
        tie_r <= 1'b0;
      end else if (cnt > top_r) begin
        top_r <= cnt;
        win_r <= pidx_r;
        tie_r <= 1'b0;
      end else if (cnt == top_r) begin
        win_r <= pidx_r;
        tie_r <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_r.class_index <= IDX_W'(idx_r);
      out_r.vote_count  <= cnt;
      out_r.winner      <= IDX_W'(win_r);
      out_r.tie         <= tie_r;
      out_r.no_data     <= !any_data_r;
      out_r.last        <= (idx_r == nc_last);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.cls_last = (class_pos_r == nc_last);
  assign sts.mdl_last = (model_pos_r == nm_last);
  assign sts.rnd_end  = rnd_end_r;
  assign sts.idx_last = (idx_r == nc_last);
  assign sts.out_free = !out_valid_r || !out_stall;

  a_vote_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.vote_wr |-> best_class_r <= nc_last)
    else $error("vote written beyond the class count");

  a_clr_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_round |=> vld_r == '0)
    else $error("counters not cleared after the round");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_v_r |-> pidx_r <= nc_last)
    else $error("scan index beyond the class count");

endmodule

### verif/tb_majority_vote_fusion_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of majority_vote_fusion_unit: directed rounds, then random ones.
// Depends on mvf_pkg and the RTL of the block; a local vote tally predicts every result that no directed row pins.
module tb_majority_vote_fusion_unit;
  import mvf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_GUARD  = 16;
  localparam int LONG_HOLD   = 400;
  localparam int RANDOM_ITEMS = 400;

  // indexes past the register list; writes to them must change nothing
  localparam logic [CFG_AW-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_AW-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum int {STY_NARROW, STY_RAIL, STY_FULL} score_style_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [CFG_AW-1:0] addr;
    logic [CFG_W-1:0]  wdata;
    mvf_in_t           item;
    logic [1:0]        n_pin;
    mvf_out_t          pin0;
    mvf_out_t          pin1;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  mvf_in_t           in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  mvf_out_t          out_data;

  majority_vote_fusion_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- vote tally
  logic [CFG_W-1:0]   nc_reg;
  logic [CFG_W-1:0]   nm_reg;
  logic [SCORE_W-1:0] best_score;
  logic [IDX_W-1:0]   best_class;
  int                 cls_pos;
  int                 mdl_pos;
  logic [VOTE_W-1:0]  votes [MVF_MAX_CLASSES];
  logic               any_data;
  mvf_out_t           round_rep [MVF_MAX_CLASSES];

  mvf_out_t vote_reports_q [$];
  int       fail_cnt = 0;
  int       reports_seen = 0;
  int       burst_left = 0;

  function automatic int eff_count(logic [CFG_W-1:0] v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic void clear_round();
    best_score = '0;
    best_class = '0;
    cls_pos = 0;
    mdl_pos = 0;
    any_data = 1'b0;
    for (int i = 0; i < MVF_MAX_CLASSES; i++) votes[i] = '0;
  endfunction

  function automatic void set_register(logic [CFG_AW-1:0] a, logic [CFG_W-1:0] v);
    if (a == REG_NUM_CLASSES) begin
      nc_reg = v;
      clear_round();
    end else if (a == REG_NUM_MODELS) begin
      nm_reg = v;
      clear_round();
    end
  endfunction

  // Advance the tally by one score; return the number of results of a finished round.
  function automatic int fuse_score(mvf_in_t d);
    int nc;
    int nm;
    int top;
    logic [IDX_W-1:0] win;
    logic tie;
    nc = eff_count(nc_reg, MVF_MAX_CLASSES);
    nm = eff_count(nm_reg, MVF_MAX_MODELS);
    if (cls_pos >= nc) cls_pos = 0;
    // a later class must be strictly better to take over
    if (cls_pos == 0 || d.score > best_score) begin
      best_score = d.score;
      best_class = IDX_W'(cls_pos);
    end
    if (cls_pos + 1 < nc) begin
      cls_pos++;
      return 0;
    end
    cls_pos = 0;
    if (d.available) begin
      any_data = 1'b1;
      if (votes[best_class] != VOTE_MAX) votes[best_class]++;
    end
    mdl_pos++;
    if (mdl_pos < nm) return 0;
    top = 0;
    win = '0;
    tie = 1'b0;
    for (int i = 0; i < nc; i++) begin
      if (i == 0) begin
        top = votes[0];
      end else if (votes[i] > top) begin
        top = votes[i];
        win = IDX_W'(i);
        tie = 1'b0;
      end else if (votes[i] == top) begin
        win = IDX_W'(i);
        tie = 1'b1;
      end
    end
    for (int i = 0; i < nc; i++) begin
      round_rep[i].class_index = IDX_W'(i);
      round_rep[i].vote_count  = votes[i];
      round_rep[i].winner      = win;
      round_rep[i].tie         = tie;
      round_rep[i].no_data     = !any_data;
      round_rep[i].last        = (i == nc - 1);
    end
    clear_round();
    return nc;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic mvf_out_t tally(int ci, int vc, int w, bit t, bit nd, bit l);
    mvf_out_t r;
    r.class_index = IDX_W'(ci);
    r.vote_count  = VOTE_W'(vc);
    r.winner      = IDX_W'(w);
    r.tie         = t;
    r.no_data     = nd;
    r.last        = l;
    return r;
  endfunction

  function automatic dir_row_t item_row(logic [SCORE_W-1:0] s, logic av, int n = 0,
                                        mvf_out_t p0 = '0, mvf_out_t p1 = '0);
    dir_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item.score = s;
    r.item.available = av;
    r.n_pin = 2'(n);
    r.pin0 = p0;
    r.pin1 = p1;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_AW-1:0] a, logic [CFG_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.addr = a;
    r.wdata = v;
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] draw_size();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return CFG_W'($urandom_range(1, 4));
    if (r < 16) return CFG_W'($urandom_range(5, 8));
    if (r < 18) return CFG_W'($urandom_range(9, 16));
    if (r == 18) return '0;
    return CFG_W'($urandom_range(17, 31));
  endfunction

  function automatic logic [SCORE_W-1:0] draw_score(score_style_e sty);
    case (sty)
      STY_NARROW: return SCORE_W'($urandom_range(0, 3));
      STY_RAIL:   return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default:    return SCORE_W'($urandom());
    endcase
  endfunction

  // Hold valid after an accepted transaction, or drop it for a gap at the end of a burst.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic offer_score(mvf_in_t d, int n_pin = 0, mvf_out_t p0 = '0,
                             mvf_out_t p1 = '0);
    int n;
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = fuse_score(d);
    if (n_pin > 0) begin
      vote_reports_q.push_back(p0);
      if (n_pin > 1) vote_reports_q.push_back(p1);
    end else begin
      for (int i = 0; i < n; i++) vote_reports_q.push_back(round_rep[i]);
    end
    pace_sender();
  endtask

  task automatic await_idle();
    in_valid <= 1'b0;
    while (vote_reports_q.size() != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] a, logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= v;
    @(posedge clk);
    set_register(a, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- result checking
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    mvf_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      reports_seen++;
      if (vote_reports_q.size() == 0) begin
        $error("result with no expectation waiting: class_index %0d", out_data.class_index);
        fail_cnt++;
      end else begin
        want = vote_reports_q.pop_front();
        check_field("class_index", want.class_index, out_data.class_index);
        check_field("vote_count", want.vote_count, out_data.vote_count);
        check_field("winner", want.winner, out_data.winner);
        check_field("tie", want.tie, out_data.tie);
        check_field("no_data", want.no_data, out_data.no_data);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  // ---------------------------------------------------------------- receiver stalls
  initial begin
    int  hold_left;
    int  stretch_left;
    int  stall_mode;
    bit  hold_done;
    hold_left = 0;
    stretch_left = 0;
    stall_mode = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      // one long hold while a round is out and the sender keeps offering: fill the block
      if (!hold_done && out_valid && in_valid && reports_seen >= 20) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(1, 40);
          stall_mode = $urandom_range(0, 3);
        end
        stretch_left--;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= $urandom_range(0, 1);
          default: out_stall <= !out_stall;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- run limit
  int cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[majority_vote_fusion_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence
  initial begin
    dir_row_t           dir_table [$];
    mvf_in_t            d;
    logic [CFG_W-1:0]   nc_w;
    logic [CFG_W-1:0]   nm_w;
    score_style_e       sty;
    int                 nc;
    int                 round_len;
    int                 n_rounds;
    int                 rnd_items;
    int                 phase;
    bit                 dead;

    nc_reg = NUM_CLASSES_RST;
    nm_reg = NUM_MODELS_RST;
    clear_round();

    // reset state: two classes, one model
    dir_table.push_back(item_row(16'h0000, 1'b0));
    dir_table.push_back(item_row(16'hFFFF, 1'b1, 2, tally(0, 0, 1, 0, 0, 0),
                                 tally(1, 1, 1, 0, 0, 1)));
    // equal scores: the first class keeps the vote
    dir_table.push_back(item_row(16'hFFFF, 1'b0));
    dir_table.push_back(item_row(16'hFFFF, 1'b1, 2, tally(0, 1, 0, 0, 0, 0),
                                 tally(1, 0, 0, 0, 0, 1)));
    // only the flag on the last class counts: no model available
    dir_table.push_back(item_row(16'h1234, 1'b1));
    dir_table.push_back(item_row(16'h0001, 1'b0, 2, tally(0, 0, 1, 1, 1, 0),
                                 tally(1, 0, 1, 1, 1, 1)));
    // a write past the register list leaves the round running
    dir_table.push_back(item_row(16'h0100, 1'b1));
    dir_table.push_back(cfg_row(REG_SPARE_2, 5'd31));
    dir_table.push_back(item_row(16'h00FF, 1'b1));
    // a real write abandons the half-done round; zero acts as one
    dir_table.push_back(item_row(16'h8000, 1'b1));
    dir_table.push_back(cfg_row(REG_NUM_CLASSES, 5'd0));
    dir_table.push_back(cfg_row(REG_NUM_MODELS, 5'd0));
    dir_table.push_back(item_row(16'hABCD, 1'b1, 1, tally(0, 1, 0, 0, 0, 1)));
    dir_table.push_back(item_row(16'hFFFF, 1'b0, 1, tally(0, 0, 0, 0, 1, 1)));
    // class count above range clamps to the maximum
    dir_table.push_back(cfg_row(REG_SPARE_3, 5'd7));
    dir_table.push_back(cfg_row(REG_NUM_CLASSES, 5'd20));
    for (int k = 0; k < MVF_MAX_CLASSES; k++)
      dir_table.push_back(item_row(SCORE_W'(k * 16'h1111), k == MVF_MAX_CLASSES - 1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[k]) begin
      if (dir_table[k].kind == ROW_CFG) begin
        await_idle();
        write_reg(dir_table[k].addr, dir_table[k].wdata);
      end else begin
        offer_score(dir_table[k].item, dir_table[k].n_pin, dir_table[k].pin0,
                    dir_table[k].pin1);
      end
    end

    rnd_items = 0;
    phase = 0;
    while (rnd_items < RANDOM_ITEMS) begin
      await_idle();
      if (phase == 0) begin
        nc_w = 5'd16;
        nm_w = 5'd3;
      end else if (phase == 1) begin
        nc_w = 5'd1;
        nm_w = 5'd31;
      end else begin
        nc_w = draw_size();
        // keep rounds short: redraw the model count when the round grows too long
        do nm_w = draw_size();
        while (eff_count(nc_w, MVF_MAX_CLASSES) * eff_count(nm_w, MVF_MAX_MODELS) > 48);
      end
      if ($urandom_range(0, 1)) begin
        write_reg(REG_NUM_CLASSES, nc_w);
        write_reg(REG_NUM_MODELS, nm_w);
      end else begin
        write_reg(REG_NUM_MODELS, nm_w);
        write_reg(REG_NUM_CLASSES, nc_w);
      end
      if ($urandom_range(0, 4) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom()));

      nc = eff_count(nc_reg, MVF_MAX_CLASSES);
      round_len = nc * eff_count(nm_reg, MVF_MAX_MODELS);
      n_rounds = (phase < 2) ? 2 : $urandom_range(1, 3);
      repeat (n_rounds) begin
        sty = score_style_e'($urandom_range(0, 2));
        dead = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < round_len; k++) begin
          d.score = draw_score(sty);
          if (dead)
            d.available = $urandom_range(0, 1) && (k % nc != nc - 1);
          else
            d.available = ($urandom_range(0, 6) != 0);
          offer_score(d);
          rnd_items++;
        end
      end
      // broken round: stop partway, the next register write drops it
      if (round_len > 1 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, round_len - 1)) begin
          d.score = SCORE_W'($urandom());
          d.available = $urandom_range(0, 1);
          offer_score(d);
          rnd_items++;
        end
      end
      phase++;
    end

    await_idle();
    if (fail_cnt == 0) begin
      $display("[majority_vote_fusion_unit] OK");
    end else begin
      $display("[majority_vote_fusion_unit] ERROR");
    end
    $finish;
  end

endmodule
